// ===== rtl/suv_pkg.sv =====
// Shared types and constants for the strict UTF-8 string validator.
package suv_pkg;

   localparam int unsigned LEN_W = 16;

   typedef logic [7:0]       data_type;
   typedef logic [LEN_W-1:0] len_type;
   typedef logic [1:0]       pend_type;
   typedef logic [2:0]       bound_type;

   // Allowed range of the next continuation byte; unused codes act as any
   localparam bound_type BOUND_ANY = 3'd0;  // 80..BF
   localparam bound_type BOUND_E0  = 3'd1;  // A0..BF
   localparam bound_type BOUND_ED  = 3'd2;  // 80..9F
   localparam bound_type BOUND_F0  = 3'd3;  // 90..BF
   localparam bound_type BOUND_F4  = 3'd4;  // 80..8F

   localparam pend_type PEND_NONE  = 2'd0;
   localparam pend_type PEND_ONE   = 2'd1;
   localparam pend_type PEND_TWO   = 2'd2;
   localparam pend_type PEND_THREE = 2'd3;

   localparam len_type MAX_LENGTH_RESET = 16'd4096;

   localparam data_type BYTE_NUL      = 8'h00;
   localparam data_type BYTE_TAB      = 8'h09;
   localparam data_type BYTE_LF       = 8'h0A;
   localparam data_type BYTE_CR       = 8'h0D;
   localparam data_type BYTE_SPACE    = 8'h20;
   localparam data_type BYTE_ASCII_HI = 8'h7F;
   localparam data_type BYTE_CONT_LO  = 8'h80;
   localparam data_type BYTE_8F       = 8'h8F;
   localparam data_type BYTE_90       = 8'h90;
   localparam data_type BYTE_9F       = 8'h9F;
   localparam data_type BYTE_A0       = 8'hA0;
   localparam data_type BYTE_CONT_HI  = 8'hBF;
   localparam data_type BYTE_LEAD2_LO = 8'hC2;
   localparam data_type BYTE_LEAD2_HI = 8'hDF;
   localparam data_type BYTE_E0       = 8'hE0;
   localparam data_type BYTE_ED       = 8'hED;
   localparam data_type BYTE_LEAD3_HI = 8'hEF;
   localparam data_type BYTE_F0       = 8'hF0;
   localparam data_type BYTE_F4       = 8'hF4;

   // Result of checking one non-NUL byte against the running decode state
   typedef struct packed {
      logic      ok;
      pend_type  pending;
      bound_type bound;
   } decode_type;

   // Verdict produced by the scan stage for one byte
   typedef struct packed {
      logic    emit;
      logic    valid_res;
      len_type text_length;
   } verdict_type;

   // Running scan state seen by the top level
   typedef struct packed {
      logic     decided;
      pend_type pending;
   } scan_status_type;

endpackage

// ===== rtl/suv_if.sv =====
// Channel interfaces for byte requests and verdict responses.
interface suv_req_if import suv_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type data_byte;
   logic     start_req;

   modport source (output valid, output data_byte, output start_req, input ready);
   modport sink (input valid, input data_byte, input start_req, output ready);
endinterface

interface suv_rsp_if import suv_pkg::*; ();
   logic    valid;
   logic    ready;
   logic    valid_res;
   len_type text_length;

   modport source (output valid, output valid_res, output text_length, input ready);
   modport sink (input valid, input valid_res, input text_length, output ready);
endinterface

// ===== rtl/suv_byte_check.sv =====
// UTF-8 byte classifier: checks one non-NUL byte and gives the next decode state.
module suv_byte_check import suv_pkg::*; (
   input  data_type   data_byte,
   input  pend_type   pending,
   input  bound_type  bound,
   output decode_type decode
);

   logic cont_ok;

   // Range check for a continuation byte under the current bound
   always_comb begin
      case (bound)
         BOUND_E0: cont_ok = (data_byte >= BYTE_A0) && (data_byte <= BYTE_CONT_HI);
         BOUND_ED: cont_ok = (data_byte >= BYTE_CONT_LO) && (data_byte <= BYTE_9F);
         BOUND_F0: cont_ok = (data_byte >= BYTE_90) && (data_byte <= BYTE_CONT_HI);
         BOUND_F4: cont_ok = (data_byte >= BYTE_CONT_LO) && (data_byte <= BYTE_8F);
         default:  cont_ok = (data_byte >= BYTE_CONT_LO) && (data_byte <= BYTE_CONT_HI);
      endcase
   end

   // Classify the byte as continuation, control, ASCII or lead byte
   always_comb begin
      decode.ok      = 1'b0;
      decode.pending = pending;
      decode.bound   = bound;
      if (pending != PEND_NONE) begin
         decode.ok      = cont_ok;
         decode.pending = pending - PEND_ONE;
         decode.bound   = BOUND_ANY;
      end else if (data_byte < BYTE_SPACE) begin
         decode.ok = (data_byte == BYTE_TAB) || (data_byte == BYTE_LF) ||
                     (data_byte == BYTE_CR);
      end else if (data_byte <= BYTE_ASCII_HI) begin
         decode.ok = 1'b1;
      end else if ((data_byte >= BYTE_LEAD2_LO) && (data_byte <= BYTE_LEAD2_HI)) begin
         decode.ok      = 1'b1;
         decode.pending = PEND_ONE;
         decode.bound   = BOUND_ANY;
      end else if ((data_byte >= BYTE_E0) && (data_byte <= BYTE_LEAD3_HI)) begin
         decode.ok      = 1'b1;
         decode.pending = PEND_TWO;
         decode.bound   = (data_byte == BYTE_E0) ? BOUND_E0 :
                          (data_byte == BYTE_ED) ? BOUND_ED : BOUND_ANY;
      end else if ((data_byte >= BYTE_F0) && (data_byte <= BYTE_F4)) begin
         decode.ok      = 1'b1;
         decode.pending = PEND_THREE;
         decode.bound   = (data_byte == BYTE_F0) ? BOUND_F0 :
                          (data_byte == BYTE_F4) ? BOUND_F4 : BOUND_ANY;
      end
   end

endmodule

// ===== rtl/suv_scan.sv =====
// Scan stage: running string state and the per-byte verdict decision.
module suv_scan import suv_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  data_type        data_byte,
   input  logic            start_req,
   input  len_type         max_length,
   output verdict_type     verdict,
   output scan_status_type status
);

   pend_type   pending_ff, pending_in, pending_cur;
   bound_type  bound_ff, bound_in, bound_cur;
   len_type    count_ff, count_in, count_cur, count_inc;
   logic       decided_ff, decided_in, decided_cur;
   decode_type decode;

   // Start clears the running state before the byte is checked
   always_comb begin
      pending_cur = start_req ? PEND_NONE : pending_ff;
      bound_cur   = start_req ? BOUND_ANY : bound_ff;
      count_cur   = start_req ? '0 : count_ff;
      decided_cur = start_req ? 1'b0 : decided_ff;
      count_inc   = count_cur + len_type'(1);
   end

   suv_byte_check u_byte_check (
      .data_byte (data_byte),
      .pending   (pending_cur),
      .bound     (bound_cur),
      .decode    (decode)
   );

   // Decide the verdict and the next state
   always_comb begin
      verdict     = '0;
      pending_in  = pending_cur;
      bound_in    = bound_cur;
      count_in    = count_cur;
      decided_in  = decided_cur;
      if (!decided_cur) begin
         if (count_cur >= max_length) begin
            verdict.emit = 1'b1;
            decided_in   = 1'b1;
         end else if (data_byte == BYTE_NUL) begin
            verdict.emit        = 1'b1;
            verdict.valid_res   = (pending_cur == PEND_NONE);
            verdict.text_length = (pending_cur == PEND_NONE) ? count_cur : '0;
            decided_in          = 1'b1;
         end else if (!decode.ok) begin
            verdict.emit = 1'b1;
            decided_in   = 1'b1;
         end else begin
            pending_in = decode.pending;
            bound_in   = decode.bound;
            count_in   = count_inc;
            if (count_inc >= max_length) begin
               verdict.emit = 1'b1;
               decided_in   = 1'b1;
            end
         end
      end
   end

   // Advance the state on each transfer out of the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= PEND_NONE;
         bound_ff   <= BOUND_ANY;
         count_ff   <= '0;
         decided_ff <= 1'b1;
      end else if (fire) begin
         pending_ff <= pending_in;
         bound_ff   <= bound_in;
         count_ff   <= count_in;
         decided_ff <= decided_in;
      end
   end

   assign status.decided = decided_ff;
   assign status.pending = pending_ff;

endmodule

// ===== rtl/strict_utf8_string_validator.sv =====
// Top level of the strict UTF-8 string validator.
//
// Bytes of a NUL-terminated string arrive one per transfer on the req_chan
// channel; start_req marks the first byte of a new string and clears the
// running state. One verdict (valid_res, text_length) leaves on the rsp_chan
// channel at the byte that decides it; further bytes give nothing until the
// next start. text_length is the byte count before the NUL when valid, else 0.
// csr_write_enable / csr_write_data load max_length (reset 4096); write it
// only while no string is in flight.
// Throughput: one byte per cycle while the receiver takes results, set by the
// scan stage between the input register and the result register.
// A verdict passes the input register and then the result register before it is offered.
// When the receiver stalls, the result register holds; the input register
// still takes one more byte, then req_chan.ready drops until the result goes.
// Reset (synchronous, active high) empties both registers, sets max_length
// to 4096 and leaves the block waiting for a start byte.
module strict_utf8_string_validator import suv_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   suv_req_if.sink          req_chan,
   suv_rsp_if.source        rsp_chan,
   input  logic             csr_write_enable,
   input  len_type          csr_write_data
);

   logic            s1_valid_ff, s1_valid_in;
   data_type        s1_data_ff;
   logic            s1_start_ff;
   logic            s1_fire;
   logic            req_take;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_ok_ff;
   len_type         rsp_length_ff;
   len_type         max_length_ff;
   verdict_type     verdict;
   scan_status_type status;

   // Scan a byte when the result register is free or being emptied
   assign s1_fire  = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign req_take = req_chan.valid && req_chan.ready;

   // Hold max_length
   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_write_enable) begin
         max_length_ff <= csr_write_data;
      end
   end

   // Input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff  <= req_chan.data_byte;
         s1_start_ff <= req_chan.start_req;
      end
   end

   suv_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .fire       (s1_fire),
      .data_byte  (s1_data_ff),
      .start_req  (s1_start_ff),
      .max_length (max_length_ff),
      .verdict    (verdict),
      .status     (status)
   );

   // Result register: load on scan, drop on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = verdict.emit;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && verdict.emit) begin
         rsp_ok_ff     <= verdict.valid_res;
         rsp_length_ff <= verdict.text_length;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.valid_res   = rsp_ok_ff;
   assign rsp_chan.text_length = rsp_length_ff;

   // A rejected string reports zero length
   a_reject_zero_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_length_ff == '0))
      else $error("rejected verdict carries nonzero length");

   // A verdict closes the string
   a_verdict_closes: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && verdict.emit) |=> status.decided)
      else $error("string still open after verdict");

   // An empty result register never blocks the input side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_chan.ready)
      else $error("input stalled with empty result register");

   // A closed string keeps no pending continuations after a valid verdict
   a_valid_no_pending: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && verdict.emit && verdict.valid_res) |-> (status.pending == PEND_NONE
         || s1_start_ff))
      else $error("valid verdict with continuations pending");

endmodule
